### src/xtea_pkg.sv
// ----------------------------------------------------------------------------
// xtea_pkg
// Shared types, constants and the round mixing function of the XTEA cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package xtea_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned KEY_COUNT = 4;
  localparam int unsigned KEY_IDX_W = 2;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E37_79B9;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  typedef logic [KEY_COUNT-1:0][WORD_W-1:0] key_t;

  typedef struct packed {
    logic              cmd;
    logic [WORD_W-1:0] word_first;
    logic [WORD_W-1:0] word_second;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_first;
    logic [WORD_W-1:0] result_second;
  } out_item_t;

  typedef struct packed {
    logic              cmd;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
  } stage_t;

  function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] w,
                                                 input logic [WORD_W-1:0] sum,
                                                 input logic [WORD_W-1:0] k);
    logic [WORD_W-1:0] shuffled;
    shuffled = ((w << 4) ^ (w >> 5)) + w;
    return shuffled ^ (sum + k);
  endfunction

endpackage

`default_nettype wire

### src/xtea_round.sv
// ----------------------------------------------------------------------------
// xtea_round
// One full XTEA round as two registered half-round stages, encrypt or decrypt
// per item. Round sums arrive as constants from the instantiating level.
// ----------------------------------------------------------------------------
`default_nettype none

module xtea_round import xtea_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire logic              in_valid,
  input  wire stage_t            in_stage,
  input  wire logic [WORD_W-1:0] enc_sum_a,
  input  wire logic [WORD_W-1:0] enc_sum_b,
  input  wire logic [WORD_W-1:0] dec_sum_a,
  input  wire logic [WORD_W-1:0] dec_sum_b,
  input  wire key_t              key,
  output logic                   out_valid,
  output stage_t                 out_stage
);

  logic   mid_valid;
  stage_t mid;
  stage_t mid_next;
  stage_t out_next;

  logic [WORD_W-1:0] a_word;
  logic [WORD_W-1:0] a_sum;
  logic [WORD_W-1:0] a_key;
  logic [WORD_W-1:0] a_mix;
  logic [WORD_W-1:0] b_word;
  logic [WORD_W-1:0] b_sum;
  logic [WORD_W-1:0] b_key;
  logic [WORD_W-1:0] b_mix;

  always_comb begin
    mid_next = in_stage;
    if (in_stage.cmd == CMD_DECRYPT) begin
      a_word = in_stage.x;
      a_sum  = dec_sum_a;
      a_key  = key[a_sum[12:11]];
    end else begin
      a_word = in_stage.y;
      a_sum  = enc_sum_a;
      a_key  = key[a_sum[1:0]];
    end
    a_mix = mix_word(a_word, a_sum, a_key);
    if (in_stage.cmd == CMD_DECRYPT) begin
      mid_next.y = in_stage.y - a_mix;
    end else begin
      mid_next.x = in_stage.x + a_mix;
    end
  end

  always_comb begin
    out_next = mid;
    if (mid.cmd == CMD_DECRYPT) begin
      b_word = mid.y;
      b_sum  = dec_sum_b;
      b_key  = key[b_sum[1:0]];
    end else begin
      b_word = mid.x;
      b_sum  = enc_sum_b;
      b_key  = key[b_sum[12:11]];
    end
    b_mix = mix_word(b_word, b_sum, b_key);
    if (mid.cmd == CMD_DECRYPT) begin
      out_next.x = mid.x - b_mix;
    end else begin
      out_next.y = mid.y + b_mix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      mid_valid <= in_valid;
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mid       <= mid_next;
      out_stage <= out_next;
    end
  end

endmodule

`default_nettype wire

### src/xtea_block_cipher.sv
// Each accepted item passes through every round in order before its result appears.
// Throughput: one item per cycle while the result is not stalled; each half round is one register stage.
// A stalled result holds the whole pipeline, and src_stall follows it.
// Reset (rst, synchronous) clears all stage valid bits and the four key words.
// ----------------------------------------------------------------------------
// xtea_block_cipher
// Unrolled XTEA ECB pipeline with a 128-bit key in four write-only registers.
// ----------------------------------------------------------------------------
`default_nettype none

module xtea_block_cipher import xtea_pkg::*; #(
  parameter int unsigned ROUNDS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data,
  input  wire logic                 src_valid,
  output logic                      src_stall,
  input  wire in_item_t             src_item,
  output logic                      dst_valid,
  input  wire logic                 dst_stall,
  output out_item_t                 dst_item
);

  key_t          key;
  logic          advance;
  logic [ROUNDS:0] stage_valid;
  stage_t        stage_data [ROUNDS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(KEY_COUNT))) begin
      key[cfg_index[KEY_IDX_W-1:0]] <= cfg_data;
    end
  end

  assign advance   = !(dst_valid && dst_stall);
  assign src_stall = !advance;

  assign stage_valid[0]      = src_valid;
  assign stage_data[0].cmd   = src_item.cmd;
  assign stage_data[0].x     = src_item.word_first;
  assign stage_data[0].y     = src_item.word_second;

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    localparam logic [WORD_W-1:0] EncSumA = WORD_W'(XTEA_DELTA * WORD_W'(r));
    localparam logic [WORD_W-1:0] EncSumB = WORD_W'(XTEA_DELTA * WORD_W'(r + 1));
    localparam logic [WORD_W-1:0] DecSumA = WORD_W'(XTEA_DELTA * WORD_W'(ROUNDS - r));
    localparam logic [WORD_W-1:0] DecSumB =
      WORD_W'(XTEA_DELTA * WORD_W'(ROUNDS - r - 1));

    xtea_round u_round (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .in_valid  (stage_valid[r]),
      .in_stage  (stage_data[r]),
      .enc_sum_a (EncSumA),
      .enc_sum_b (EncSumB),
      .dec_sum_a (DecSumA),
      .dec_sum_b (DecSumB),
      .key       (key),
      .out_valid (stage_valid[r+1]),
      .out_stage (stage_data[r+1])
    );
  end

  assign dst_valid              = stage_valid[ROUNDS];
  assign dst_item.result_first  = stage_data[ROUNDS].x;
  assign dst_item.result_second = stage_data[ROUNDS].y;

endmodule

`default_nettype wire

### src/xtea_checker.sv
// ----------------------------------------------------------------------------
// xtea_checker
// Port-level checks of the XTEA pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module xtea_checker import xtea_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      src_stall,
  input wire logic      dst_valid,
  input wire logic      dst_stall,
  input wire out_item_t dst_item
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !dst_valid)
    else $error("result valid after reset");

  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    src_stall == (dst_valid && dst_stall))
    else $error("input stall does not follow output stall");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    !dst_valid |-> !src_stall)
    else $error("pipeline stalls input with no held item");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (dst_valid && dst_stall) |=> (dst_valid && $stable(dst_item)))
    else $error("stalled item changed or dropped");

endmodule

bind xtea_block_cipher xtea_checker u_xtea_checker (
  .clk       (clk),
  .rst       (rst),
  .src_stall (src_stall),
  .dst_valid (dst_valid),
  .dst_stall (dst_stall),
  .dst_item  (dst_item)
);

`default_nettype wire
